>>> sv/nearest_palette_color_mapper_macros.svh
// ----------------------------------------------------------------------------
// Nearest palette color mapper assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/npcm_pkg.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper package
// Field widths, register indexes and the beat that walks the palette chain.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

  localparam int ColorW  = 8;
  localparam int IdxW    = 8;
  localparam int CoordW  = 12;
  localparam int DimW    = 13;
  localparam int AddrW   = 24;
  localparam int DistW   = 18;
  localparam int CfgIdxW = 4;
  localparam int InDataW  = 56;
  localparam int OutDataW = 56;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegScreenHeight = CfgIdxW'(1);

  localparam logic [DimW-1:0] ScreenWidthRst  = DimW'(320);
  localparam logic [DimW-1:0] ScreenHeightRst = DimW'(200);

  // Three channels, each at most 255 squared.
  localparam logic [DistW-1:0] MaxDist = DistW'(195075);

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_t;

  // One beat of the chain. For a palette write, index is the entry to
  // write; for a pixel, it is the best entry found so far.
  typedef struct packed {
    logic             valid;
    logic             is_write;
    color_t           color;
    logic [IdxW-1:0]  index;
    logic [AddrW-1:0] addr;
    logic [DistW-1:0] sqdist;
  } beat_t;

endpackage

`default_nettype wire

>>> sv/npcm_front.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper front end
// Clips pixels to the screen and forms the linear address in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_front import npcm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic              cmd_i,
  input  wire logic [IdxW-1:0]   entry_index_i,
  input  wire logic [CoordW-1:0] pixel_x_i,
  input  wire logic [CoordW-1:0] pixel_y_i,
  input  wire color_t            color_i,
  input  wire logic [DimW-1:0]   screen_width_i,
  input  wire logic [DimW-1:0]   screen_height_i,
  output beat_t                  beat_o
);

  beat_t             s1_q, s1_d;
  logic [CoordW-1:0] px_q;
  beat_t             beat_q, beat_d;
  logic              on_screen;
  logic [CoordW+DimW-1:0] prod;

  assign on_screen = ({1'b0, pixel_x_i} < screen_width_i) &&
                     ({1'b0, pixel_y_i} < screen_height_i);
  assign prod = pixel_y_i * screen_width_i;

  always_comb begin
    s1_d          = '0;
    s1_d.valid    = valid_i && (!cmd_i || on_screen);
    s1_d.is_write = !cmd_i;
    s1_d.color    = color_i;
    s1_d.index    = entry_index_i;
    s1_d.addr     = prod[AddrW-1:0];
  end

  always_comb begin
    beat_d      = s1_q;
    beat_d.addr = s1_q.addr + AddrW'(px_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      beat_q <= '0;
    end else if (adv_i) begin
      s1_q   <= s1_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q <= pixel_x_i;
    end
  end

  assign beat_o = beat_q;

endmodule

`default_nettype wire

>>> sv/npcm_cell.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper cell
// Holds one palette entry and keeps the running nearest match of a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_cell import npcm_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire beat_t beat_i,
  output beat_t      beat_o
);

  localparam logic [IdxW-1:0] MyIdx   = IdxW'(CELL_INDEX);
  localparam bit              IsFirst = (CELL_INDEX == 0);

  color_t             entry_q;
  beat_t              beat_q, beat_d;
  logic [ColorW-1:0]  dr, dg, db;
  logic [2*ColorW-1:0] sr, sg, sb;
  logic [DistW-1:0]   cand_sqdist;
  logic               take;
  logic               hit_write;

  always_comb begin
    dr = (beat_i.color.red > entry_q.red) ? beat_i.color.red - entry_q.red
                                          : entry_q.red - beat_i.color.red;
    dg = (beat_i.color.green > entry_q.green) ? beat_i.color.green - entry_q.green
                                              : entry_q.green - beat_i.color.green;
    db = (beat_i.color.blue > entry_q.blue) ? beat_i.color.blue - entry_q.blue
                                            : entry_q.blue - beat_i.color.blue;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    cand_sqdist = DistW'(sr) + DistW'(sg) + DistW'(sb);
  end

  // A strict compare keeps the earlier, lower index on a tie.
  assign take      = IsFirst || (cand_sqdist < beat_i.sqdist);
  assign hit_write = beat_i.valid && beat_i.is_write && (beat_i.index == MyIdx);

  always_comb begin
    beat_d = beat_i;
    if (beat_i.valid && !beat_i.is_write && take) begin
      beat_d.index  = MyIdx;
      beat_d.sqdist = cand_sqdist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      beat_q  <= '0;
    end else if (adv_i) begin
      beat_q <= beat_d;
      if (hit_write) begin
        entry_q <= beat_i.color;
      end
    end
  end

  assign beat_o = beat_q;

endmodule

`default_nettype wire

>>> sv/nearest_palette_color_mapper.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper
// Maps RGB pixels to the nearest palette entry through a chain of cells.
// ----------------------------------------------------------------------------
// Each palette entry lives in its own cell, and every beat walks the chain
// one cell per clock while the output is not stalled, so a pixel's result
// reaches the output through two front stages, one cell per entry and one
// output register, the first of them loaded by the accepting edge. The
// chain takes one beat per clock as long as the output is not stalled; a
// stall freezes the whole chain. Palette writes travel down the same chain
// and update their cell on the way, so they affect exactly the pixels that
// follow them. Writes and off-screen pixels give no result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_mapper_macros.svh"

module nearest_palette_color_mapper import npcm_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [DimW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // entry_index[7:0], pixel_x[19:8], pixel_y[31:20], red[39:32],
  // green[47:40], blue[55:48]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // screen_address[23:0], color_index[31:24], best_distance[49:32]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic              adv;
  logic [DimW-1:0]   width_q, height_q;
  color_t            in_color;
  beat_t             chain [PALETTE_ENTRIES+1];
  beat_t             last;
  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [IdxW-1:0]   out_index_q;
  logic [DistW-1:0]  out_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegScreenWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == RegScreenHeight) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_color.red   = s_axis_tdata[39:32];
  assign in_color.green = s_axis_tdata[47:40];
  assign in_color.blue  = s_axis_tdata[55:48];

  npcm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (s_axis_tvalid),
    .cmd_i           (s_axis_tuser),
    .entry_index_i   (s_axis_tdata[7:0]),
    .pixel_x_i       (s_axis_tdata[19:8]),
    .pixel_y_i       (s_axis_tdata[31:20]),
    .color_i         (in_color),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .beat_o          (chain[0])
  );

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  assign last = chain[PALETTE_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid && !last.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_addr_q  <= last.addr;
      out_index_q <= last.index;
      out_dist_q  <= last.sqdist;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_dist_q, out_index_q, out_addr_q};

  `NPCM_ASSERT_NEXT(a_chain_holds_on_stall, out_valid_q && !m_axis_tready,
                    $stable(last), "chain moved while the output was stalled")
  `NPCM_ASSERT_SAME(a_no_write_result, $rose(out_valid_q),
                    !$past(last.is_write), "a palette write produced a result")
  `NPCM_ASSERT_SAME(a_dist_in_range, out_valid_q, out_dist_q <= MaxDist,
                    "best distance above the largest possible RGB distance")

endmodule

`default_nettype wire

>>> tb/sv/nearest_palette_color_mapper_tb.sv
// ----------------------------------------------------------------------------
// Nearest palette color mapper testbench
// Streams palette writes and pixels through the mapper under random bursts,
// gaps and output stalls, and checks every result beat against a local
// model of the palette search, clipping and address arithmetic.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_tb import npcm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PaletteDepth = 256;
  localparam int ChainLatency = PaletteDepth + 3;
  localparam int DrainCycles  = ChainLatency + 16;
  localparam int HoldCycles   = 800;
  localparam int CycleLimit   = 400000;

  localparam logic CmdPaletteWrite = 1'b0;
  localparam logic CmdMapPixel     = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IdxW-1:0]   entry;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    color_t            color;
  } mapper_item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [IdxW-1:0]  index;
    logic [DistW-1:0] sqdist;
  } mapped_pixel_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [DimW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  nearest_palette_color_mapper #(
    .PALETTE_ENTRIES(PaletteDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Model state, updated on accepted beats only.
  logic [DimW-1:0] width_mirror  = ScreenWidthRst;
  logic [DimW-1:0] height_mirror = ScreenHeightRst;
  color_t          palette_mirror [PaletteDepth];
  mapped_pixel_t   mapped_expected [$];

  mapper_item_t item_backlog [$];
  mapper_item_t next_item;
  color_t       recent_colors [$];
  int           gen_width  = 320;
  int           gen_height = 200;

  bit in_accepted = 1'b0;
  bit tx_steady   = 1'b0;
  bit rx_open     = 1'b0;
  int burst_left  = 0;
  int gap_left    = 0;
  int rx_seg_left = 0;
  int rx_mode     = 0;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  initial begin
    for (int i = 0; i < PaletteDepth; i++) palette_mirror[i] = '0;
  end

  // Applies one accepted input beat to the model and queues its result, if it has one.
  function automatic void predict_mapping(input logic cmd, input logic [InDataW-1:0] data);
    logic [IdxW-1:0]   entry;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    color_t            pix;
    mapped_pixel_t     res;
    int                min_sqdist;
    int                min_entry;
    int                d;
    int                dr;
    int                dg;
    int                db;
    entry = data[7:0];
    px    = data[19:8];
    py    = data[31:20];
    pix   = {data[39:32], data[47:40], data[55:48]};
    if (cmd == CmdPaletteWrite) begin
      if (int'(entry) < PaletteDepth) palette_mirror[entry] = pix;
      return;
    end
    if (px >= width_mirror || py >= height_mirror) return;
    min_sqdist = 0;
    min_entry  = 0;
    for (int i = 0; i < PaletteDepth; i++) begin
      dr = int'(pix.red)   - int'(palette_mirror[i].red);
      dg = int'(pix.green) - int'(palette_mirror[i].green);
      db = int'(pix.blue)  - int'(palette_mirror[i].blue);
      d  = dr * dr + dg * dg + db * db;
      if (i == 0 || d < min_sqdist) begin
        min_sqdist = d;
        min_entry  = i;
      end
    end
    res.addr   = AddrW'(int'(py) * int'(width_mirror) + int'(px));
    res.index  = IdxW'(min_entry);
    res.sqdist = DistW'(min_sqdist);
    mapped_expected.push_back(res);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_accepted) begin
      // The offered beat has not been taken yet and stays on the bus.
    end else if (gap_left > 0 && !tx_steady) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (item_backlog.size() > 0) begin
      next_item = item_backlog.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= next_item.cmd;
      s_axis_tdata  <= {next_item.color.blue, next_item.color.green, next_item.color.red,
                        next_item.y, next_item.x, next_item.entry};
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(0, 3);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: segments of steady, random and mostly stalled readiness,
  // plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(8, 64);
      rx_mode     = $urandom_range(0, 2);
    end
    rx_seg_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_open || rx_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      m_axis_tready <= 1'($urandom_range(0, 1));
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: model update on input beats, comparison on output beats.
  always @(posedge clk_i) begin
    mapped_pixel_t exp_res;
    in_accepted = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegScreenWidth:  width_mirror  = cfg_data_i;
        RegScreenHeight: height_mirror = cfg_data_i;
        default: ;
      endcase
    end
    if (in_accepted) predict_mapping(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mapped_expected.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h", m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_res = mapped_expected.pop_front();
        if (m_axis_tdata[23:0] !== exp_res.addr) begin
          $error("screen_address: expected %0d, actual %0d", exp_res.addr, m_axis_tdata[23:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[31:24] !== exp_res.index) begin
          $error("color_index: expected %0d, actual %0d", exp_res.index, m_axis_tdata[31:24]);
          mismatch_count++;
        end
        if (m_axis_tdata[49:32] !== exp_res.sqdist) begin
          $error("best_distance: expected %0d, actual %0d", exp_res.sqdist,
                 m_axis_tdata[49:32]);
          mismatch_count++;
        end
      end
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void push_write(input int idx, input int r, input int g, input int b);
    mapper_item_t it;
    it.cmd   = CmdPaletteWrite;
    it.entry = IdxW'(idx);
    it.x     = CoordW'($urandom_range(0, 4095));
    it.y     = CoordW'($urandom_range(0, 4095));
    it.color = {ColorW'(r), ColorW'(g), ColorW'(b)};
    item_backlog.push_back(it);
  endfunction

  function automatic void push_pixel(input int px, input int py,
                                     input int r, input int g, input int b);
    mapper_item_t it;
    it.cmd   = CmdMapPixel;
    it.entry = IdxW'($urandom_range(0, 255));
    it.x     = CoordW'(px);
    it.y     = CoordW'(py);
    it.color = {ColorW'(r), ColorW'(g), ColorW'(b)};
    item_backlog.push_back(it);
  endfunction

  // Random mix: a quarter palette writes, the rest pixels, mostly on screen.
  // Colors reuse recent palette entries often so that exact hits and ties occur.
  function automatic void push_random(input int count);
    mapper_item_t it;
    int           span_x;
    int           span_y;
    int           pick;
    span_x = (gen_width > 4096) ? 4096 : gen_width;
    span_y = (gen_height > 4096) ? 4096 : gen_height;
    for (int n = 0; n < count; n++) begin
      it.cmd   = ($urandom_range(0, 3) == 0) ? CmdPaletteWrite : CmdMapPixel;
      it.entry = IdxW'($urandom_range(0, 255));
      if (span_x > 0 && span_y > 0 && $urandom_range(0, 3) != 0) begin
        it.x = CoordW'($urandom_range(0, span_x - 1));
        it.y = CoordW'($urandom_range(0, span_y - 1));
      end else begin
        it.x = CoordW'($urandom_range(0, 4095));
        it.y = CoordW'($urandom_range(0, 4095));
      end
      pick = $urandom_range(0, 5);
      if (pick == 0 && recent_colors.size() > 0) begin
        it.color = recent_colors[$urandom_range(0, recent_colors.size() - 1)];
      end else if (pick == 1) begin
        it.color.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        it.color.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        it.color.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end else begin
        it.color = color_t'(24'($urandom_range(0, 24'hffffff)));
      end
      if (it.cmd == CmdPaletteWrite) begin
        recent_colors.push_back(it.color);
        if (recent_colors.size() > 16) void'(recent_colors.pop_front());
      end
      item_backlog.push_back(it);
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_screen(input int w, input int h);
    write_reg(RegScreenWidth, DimW'(w));
    write_reg(RegScreenHeight, DimW'(h));
    gen_width  = w;
    gen_height = h;
  endtask

  // Waits until every beat is taken and every result is back, then lets the
  // chain empty out, since writes and clipped pixels leave no result behind.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (item_backlog.size() != 0 || s_axis_tvalid || mapped_expected.size() != 0);
    rx_open = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    rx_open = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset screen, palette all black.
    push_pixel(0, 0, 0, 0, 0);
    push_pixel(319, 199, 255, 255, 255);
    push_pixel(320, 0, 1, 2, 3);
    push_pixel(0, 200, 1, 2, 3);
    push_pixel(4095, 4095, 1, 2, 3);
    push_write(255, 255, 255, 255);
    push_pixel(5, 5, 255, 255, 254);
    // Two entries with one color: the lower index must win.
    push_write(1, 10, 20, 30);
    push_write(2, 10, 20, 30);
    push_pixel(1, 1, 10, 20, 30);
    push_write(0, 10, 20, 30);
    push_pixel(2, 2, 10, 20, 30);
    push_write(128, 0, 255, 0);
    push_pixel(100, 100, 0, 250, 0);
    wait_drained();

    // A zero width or height clips every pixel.
    set_screen(0, 4096);
    push_pixel(0, 0, 9, 9, 9);
    push_pixel(4095, 0, 9, 9, 9);
    wait_drained();
    set_screen(4096, 0);
    push_pixel(0, 0, 9, 9, 9);
    wait_drained();

    set_screen(1, 1);
    push_pixel(0, 0, 200, 100, 50);
    push_pixel(1, 0, 200, 100, 50);
    push_pixel(0, 1, 200, 100, 50);
    wait_drained();

    // Oversized registers: the address wraps to 24 bits.
    set_screen(8191, 8191);
    push_pixel(4095, 4095, 255, 0, 255);
    push_pixel(0, 4095, 0, 255, 0);
    push_random(150);
    wait_drained();

    set_screen(4096, 4096);
    push_random(200);
    wait_drained();

    set_screen($urandom_range(1, 640), $urandom_range(1, 480));
    push_random(200);
    wait_drained();

    // Back-pressure: the output holds off long enough for the chain to fill
    // while the sender keeps offering beats.
    set_screen(640, 480);
    tx_steady = 1'b1;
    hold_req++;
    push_random(250);
    wait_drained();
    tx_steady = 1'b0;

    set_screen(320, 200);
    push_random(100);
    wait_drained();

    if (mismatch_count == 0 && mapped_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
